>>> sv/pstc_pkg.sv
// Shared types and constants for the PID steer/throttle controller.
// No dependencies; imported by pid_steer_throttle_controller.
package pstc_pkg;

  localparam int ErrW     = 16;
  localparam int SpdW     = 16;
  localparam int GainW    = 16;
  localparam int IntW     = 32;
  localparam int SteerW   = 24;
  localparam int ThrW     = 2;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;
  localparam int DiffW    = ErrW + 1;
  localparam int MulAW    = 32;
  localparam int MulBW    = 22;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AccW     = 63;
  localparam int RndW     = AccW - 25;

  localparam logic [CfgIdxW-1:0] REG_GAIN_P    = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I    = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D    = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_LOW_SPEED = 8'd3;

  localparam logic [ThrW-1:0] THR_BRAKE  = 2'd0;
  localparam logic [ThrW-1:0] THR_CRUISE = 2'd1;
  localparam logic [ThrW-1:0] THR_BOOST  = 2'd2;

  localparam logic [SpdW-1:0] LOW_SPEED_RESET = 16'd160;

endpackage

>>> sv/pid_steer_throttle_controller.sv
// PID steer/throttle controller, trapezoidal integral, one shared multiplier.
// Depends on pstc_pkg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------
//   in       | in_valid / in_stall  | error_sample, speed_sample
//   out      | out_valid / out_stall| steer_value, throttle_code
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each item takes the accept cycle plus six sequencer steps, four of them on the
// single 32x22 signed multiplier (Kp*e, *scale, Ki*I, Kd*d); items never overlap.
// Reset clears the gains, last error and integral and sets the speed limit to 10.0.
// The result waits in the output register while the next item is accepted;
// the final step holds only if the previous result has not been taken yet.
module pid_steer_throttle_controller
  import pstc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [ErrW-1:0]     error_sample,
  input  logic        [SpdW-1:0]     speed_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SteerW-1:0]   steer_value,
  output logic        [ThrW-1:0]     throttle_code,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic        [CfgIdxW-1:0]  cfg_index,
  input  logic        [CfgDataW-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_P1, S_P2, S_I, S_D, S_SUM, S_ROUND
  } state_t;

  state_t state;

  logic        [GainW-1:0]  gain_p, gain_i, gain_d;
  logic        [SpdW-1:0]   low_speed_limit;
  logic signed [ErrW-1:0]   last_error;
  logic signed [IntW-1:0]   integral;

  logic signed [ErrW-1:0]   e_r;
  logic        [SpdW-1:0]   speed_r;
  logic signed [DiffW-1:0]  d_r;
  logic signed [MulBW-1:0]  scale_r;
  logic        [ThrW-1:0]   thr_r;
  logic signed [ProdW-1:0]  prod_r;
  logic signed [AccW-1:0]   acc;

  logic                     in_acc, out_free;
  logic signed [DiffW-1:0]  diff;
  logic signed [IntW+1:0]   isum;
  logic signed [IntW-1:0]   integral_next;

  logic signed [20:0]       d10;
  logic signed [21:0]       d20;
  logic signed [26:0]       d500;
  logic signed [18:0]       e5;
  logic signed [MulBW-1:0]  scale_next;
  logic        [ThrW-1:0]   thr_next;

  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  mul_p;
  logic signed [AccW-1:0]   prod_ext;
  logic signed [AccW-1:0]   rnd;
  logic signed [RndW-1:0]   rsh;
  logic signed [SteerW-1:0] steer_next;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // input step: difference and saturating trapezoidal sum
  always_comb begin
    diff = {error_sample[ErrW-1], error_sample} - {last_error[ErrW-1], last_error};
    isum = {{2{integral[IntW-1]}}, integral}
         + {{(IntW+2-ErrW){error_sample[ErrW-1]}}, error_sample}
         + {{(IntW+2-ErrW){last_error[ErrW-1]}}, last_error};
    if (isum[IntW+1:IntW-1] == 3'b000 || isum[IntW+1:IntW-1] == 3'b111) begin
      integral_next = isum[IntW-1:0];
    end else if (isum[IntW+1]) begin
      integral_next = {1'b1, {(IntW-1){1'b0}}};
    end else begin
      integral_next = {1'b0, {(IntW-1){1'b1}}};
    end
  end

  // proportional scale and throttle decision
  always_comb begin
    d10  = ({{4{d_r[DiffW-1]}}, d_r} <<< 3) + ({{4{d_r[DiffW-1]}}, d_r} <<< 1);
    d20  = {d10[20], d10} <<< 1;
    d500 = {{10{d_r[DiffW-1]}}, d_r} * 27'sd500;
    e5   = ({{3{e_r[ErrW-1]}}, e_r} <<< 2) + {{3{e_r[ErrW-1]}}, e_r};

    if (e_r > 16'sd4096 && d10 > 21'sd4096) begin
      scale_next = 22'sd8192 + {d10[20], d10};
    end else if (e_r < -16'sd4096 && d10 < -21'sd4096) begin
      scale_next = 22'sd8192 - {d10[20], d10};
    end else begin
      scale_next = 22'sd4096;
    end

    thr_next = THR_CRUISE;
    if (e_r > 16'sd4096 && d20 > 22'sd4096) begin
      thr_next = THR_BRAKE;
    end else if (e5 > 19'sd24576 && d500 > 27'sd4096) begin
      thr_next = THR_BRAKE;
    end else if (e_r < -16'sd4096 && d20 < -22'sd4096) begin
      thr_next = THR_BRAKE;
    end else if (e5 < -19'sd24576 && d500 < -27'sd4096) begin
      thr_next = THR_BRAKE;
    end
    if (speed_r < low_speed_limit) begin
      thr_next = THR_BOOST;
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_P1: begin
        mul_a = {{(MulAW-ErrW){e_r[ErrW-1]}}, e_r};
        mul_b = {{(MulBW-GainW){1'b0}}, gain_p};
      end
      S_P2: begin
        mul_a = prod_r[MulAW-1:0];
        mul_b = scale_r;
      end
      S_I: begin
        mul_a = integral;
        mul_b = {{(MulBW-GainW){1'b0}}, gain_i};
      end
      S_D: begin
        mul_a = {{(MulAW-DiffW){d_r[DiffW-1]}}, d_r};
        mul_b = {{(MulBW-GainW){1'b0}}, gain_d};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p    = mul_a * mul_b;
    prod_ext = {{(AccW-ProdW){prod_r[ProdW-1]}}, prod_r};
  end

  // negate, round half up from Q37 to Q12, saturate
  always_comb begin
    rnd = -acc + ({{(AccW-1){1'b0}}, 1'b1} <<< 24);
    rsh = rnd[AccW-1:25];
    if (rsh > 38'sd8388607) begin
      steer_next = {1'b0, {(SteerW-1){1'b1}}};
    end else if (rsh < -38'sd8388608) begin
      steer_next = {1'b1, {(SteerW-1){1'b0}}};
    end else begin
      steer_next = rsh[SteerW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      low_speed_limit <= LOW_SPEED_RESET;
      last_error      <= '0;
      integral        <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_ROUND) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GAIN_P:    gain_p          <= cfg_data;
          REG_GAIN_I:    gain_i          <= cfg_data;
          REG_GAIN_D:    gain_d          <= cfg_data;
          REG_LOW_SPEED: low_speed_limit <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            e_r        <= error_sample;
            speed_r    <= speed_sample;
            d_r        <= diff;
            integral   <= integral_next;
            last_error <= error_sample;
            state      <= S_P1;
          end
        end
        S_P1: begin
          prod_r  <= mul_p;
          scale_r <= scale_next;
          thr_r   <= thr_next;
          state   <= S_P2;
        end
        S_P2: begin
          prod_r <= mul_p;
          state  <= S_I;
        end
        S_I: begin
          acc    <= prod_ext <<< 1;
          prod_r <= mul_p;
          state  <= S_D;
        end
        S_D: begin
          acc    <= acc + (prod_ext <<< 12);
          prod_r <= mul_p;
          state  <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + (prod_ext <<< 13);
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (out_free) begin
            steer_value   <= steer_next;
            throttle_code <= thr_r;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_result_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_ROUND))
    else $error("result appeared outside the final step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("input not stalled after a transaction");

  a_state_held_when_idle: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> ($stable(integral) && $stable(last_error)))
    else $error("controller state changed without an input transaction");
`endif

endmodule
